// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the range-add range-sum tree.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRST_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrst assertion failed");

`endif

// ----- hw/rtl/rrst_pkg.sv -----
// Constants and types of the range-add range-sum tree.
// No dependencies; used by rrst_ctrl and the top level.
package rrst_pkg;

    localparam int LEAVES     = 1024;
    localparam int LOG_LEAVES = $clog2(LEAVES);
    localparam int DEPTH      = 2 * LEAVES;
    localparam int NODE_W     = LOG_LEAVES + 1;
    localparam int PTR_W      = NODE_W + 1;
    localparam int LVL_W      = $clog2(LOG_LEAVES + 1);
    localparam int SUM_W      = 64;
    localparam int VAL_W      = 32;
    localparam int START_W    = 10;
    localparam int END_W      = 11;

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_SUM = 1'b1;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic [SUM_W-1:0]  data;
    } mem_wr_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } res_t;

endpackage

// ----- hw/rtl/rrst_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module rrst_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/rrst_ctrl.sv -----
// Sequencer of the range-add range-sum tree: clears both node memories,
// walks range level by level; read-modify-writes (add) or sums (sum)
// nodes and ancestors. Depends on rrst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrst_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [rrst_pkg::START_W-1:0]   s_range_start,
    input  logic [rrst_pkg::END_W-1:0]     s_range_end,
    input  logic signed [rrst_pkg::VAL_W-1:0] s_add_value,
    output rrst_pkg::res_t                 res,
    input  logic                           res_ready,
    output rrst_pkg::mem_wr_t              sum_wr,
    output logic [rrst_pkg::NODE_W-1:0]    sum_raddr,
    input  logic [rrst_pkg::SUM_W-1:0]     sum_rdata,
    output rrst_pkg::mem_wr_t              add_wr,
    output logic [rrst_pkg::NODE_W-1:0]    add_raddr,
    input  logic [rrst_pkg::SUM_W-1:0]     add_rdata
);

    localparam int NODE_W = rrst_pkg::NODE_W;
    localparam int PTR_W  = rrst_pkg::PTR_W;
    localparam int LVL_W  = rrst_pkg::LVL_W;
    localparam int SUM_W  = rrst_pkg::SUM_W;
    localparam logic [PTR_W-1:0] LEAVES_P = PTR_W'(rrst_pkg::LEAVES);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_WALK   = 8'b0000_0100,
        ST_NODE_RD = 8'b0000_1000,
        ST_NODE_WR = 8'b0001_0000,
        ST_ANC_RD = 8'b0010_0000,
        ST_ANC_WR = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        STEP_LO    = 3'b001,
        STEP_HI    = 3'b010,
        STEP_SHIFT = 3'b100
    } step_t;

    state_t              state_reg, state_next;
    step_t               step_reg, step_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    logic                is_add_reg, is_add_next;
    logic [SUM_W-1:0]    val_reg, val_next;
    logic [PTR_W-1:0]    lo_reg, lo_next;
    logic [PTR_W-1:0]    hi_reg, hi_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;

    logic [PTR_W-1:0]    start_ext, end_ext, lo_sat, hi_sat, hi_dec;
    logic [NODE_W-1:0]   parent;
    logic [SUM_W-1:0]    scaled;

    assign start_ext = PTR_W'(s_range_start);
    assign end_ext   = PTR_W'(s_range_end);
    assign lo_sat    = (start_ext > LEAVES_P) ? LEAVES_P : start_ext;
    assign hi_sat    = (end_ext > LEAVES_P) ? LEAVES_P : end_ext;
    assign hi_dec    = hi_reg - PTR_W'(1);
    assign parent    = node_reg >> 1;
    // per-element add scaled by node size (2^level)
    assign scaled    = (is_add_reg ? val_reg : add_rdata) << lvl_reg;
    assign sum_raddr = node_reg;
    assign add_raddr = node_reg;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        clr_next    = clr_reg;
        is_add_next = is_add_reg;
        val_next    = val_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        lvl_next    = lvl_reg;
        node_next   = node_reg;
        acc_next    = acc_reg;
        s_ready     = 1'b0;
        res.valid   = 1'b0;
        res.sum     = acc_reg;
        sum_wr      = '0;
        add_wr      = '0;
        case (state_reg)
            ST_CLEAR: begin
                sum_wr.we   = 1'b1;
                sum_wr.addr = clr_reg;
                add_wr.we   = 1'b1;
                add_wr.addr = clr_reg;
                clr_next    = clr_reg + NODE_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    is_add_next = (s_func == rrst_pkg::FUNC_ADD);
                    val_next    = SUM_W'(s_add_value);
                    lo_next     = lo_sat + LEAVES_P;
                    hi_next     = hi_sat + LEAVES_P;
                    lvl_next    = '0;
                    step_next   = STEP_LO;
                    acc_next    = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                case (step_reg)
                    STEP_LO: begin
                        if (lo_reg >= hi_reg) begin
                            state_next = is_add_reg ? ST_IDLE : ST_DONE;
                        end else if (lo_reg[0]) begin
                            node_next  = lo_reg[NODE_W-1:0];
                            lo_next    = lo_reg + PTR_W'(1);
                            step_next  = STEP_HI;
                            state_next = ST_NODE_RD;
                        end else begin
                            step_next = STEP_HI;
                        end
                    end
                    STEP_HI: begin
                        step_next = STEP_SHIFT;
                        if (hi_reg[0]) begin
                            hi_next    = hi_dec;
                            node_next  = hi_dec[NODE_W-1:0];
                            state_next = ST_NODE_RD;
                        end
                    end
                    STEP_SHIFT: begin
                        lo_next   = lo_reg >> 1;
                        hi_next   = hi_reg >> 1;
                        lvl_next  = lvl_reg + LVL_W'(1);
                        step_next = STEP_LO;
                    end
                    default: begin
                        step_next = STEP_LO;
                    end
                endcase
            end
            ST_NODE_RD: begin
                state_next = ST_NODE_WR;
            end
            ST_NODE_WR: begin
                if (is_add_reg) begin
                    add_wr.we   = 1'b1;
                    add_wr.addr = node_reg;
                    add_wr.data = add_rdata + val_reg;
                end else begin
                    acc_next = acc_reg + sum_rdata + scaled;
                end
                node_next  = parent;
                state_next = (parent == '0) ? ST_WALK : ST_ANC_RD;
            end
            ST_ANC_RD: begin
                state_next = ST_ANC_WR;
            end
            ST_ANC_WR: begin
                if (is_add_reg) begin
                    sum_wr.we   = 1'b1;
                    sum_wr.addr = node_reg;
                    sum_wr.data = sum_rdata + scaled;
                end else begin
                    acc_next = acc_reg + scaled;
                end
                node_next  = parent;
                state_next = (parent == '0) ? ST_WALK : ST_ANC_RD;
            end
            ST_DONE: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= STEP_LO;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
        end
        is_add_reg <= is_add_next;
        val_reg    <= val_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lvl_reg    <= lvl_next;
        node_reg   <= node_next;
        acc_reg    <= acc_next;
    end

    `RRST_ASSERT_IMPL(a_walk_order, aclk, aresetn,
        (state_reg == ST_WALK && step_reg != STEP_LO), (lo_reg <= hi_reg))
    `RRST_ASSERT_IMPL(a_sum_wr_state, aclk, aresetn,
        sum_wr.we, (state_reg == ST_CLEAR || state_reg == ST_ANC_WR))
    `RRST_ASSERT_IMPL(a_add_wr_state, aclk, aresetn,
        add_wr.we, (state_reg == ST_CLEAR || state_reg == ST_NODE_WR))
    `RRST_ASSERT_IMPL(a_res_only_sum, aclk, aresetn, res.valid, !is_add_reg)
    `RRST_ASSERT_NEXT(a_done_to_idle, aclk, aresetn, (res.valid && res_ready), s_ready)

endmodule

// ----- hw/rtl/range_add_range_sum_tree.sv -----
// Range-add / range-sum segment tree over 1024 elements, top level.
// Input channel s_*: a request adds s_add_value to every element of
// [s_range_start, s_range_end) (s_func = 0) or asks for the sum over that
// range (s_func = 1). Bounds above 1024 saturate; an empty range changes
// nothing and sums to zero.
// Result channel m_*: one 64-bit wrapping sum per sum request, none per add.
// After reset the node memories are cleared, one entry a cycle over all 2048
// entries; s_ready stays low during that pass.
// A request walks the tree level by level: low bound, high bound, shift.
// Each covering node and each of its ancestors is one read then one write or
// accumulate on the single-read-port node memories.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is accepted and worked, and a second sum waits for
// the register to drain before it finishes.
// Depends on rrst_pkg, rrst_ram and rrst_ctrl.
module range_add_range_sum_tree (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [rrst_pkg::START_W-1:0]      s_range_start,
    input  logic [rrst_pkg::END_W-1:0]        s_range_end,
    input  logic signed [rrst_pkg::VAL_W-1:0] s_add_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [rrst_pkg::SUM_W-1:0] m_range_sum
);

    rrst_pkg::res_t                   res;
    logic                             res_ready;
    rrst_pkg::mem_wr_t                sum_wr, add_wr;
    logic [rrst_pkg::NODE_W-1:0]      sum_raddr, add_raddr;
    logic [rrst_pkg::SUM_W-1:0]       sum_rdata, add_rdata;
    logic                             m_valid_reg, m_valid_next;
    logic [rrst_pkg::SUM_W-1:0]       m_sum_reg, m_sum_next;

    rrst_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_range_start (s_range_start),
        .s_range_end   (s_range_end),
        .s_add_value   (s_add_value),
        .res           (res),
        .res_ready     (res_ready),
        .sum_wr        (sum_wr),
        .sum_raddr     (sum_raddr),
        .sum_rdata     (sum_rdata),
        .add_wr        (add_wr),
        .add_raddr     (add_raddr),
        .add_rdata     (add_rdata)
    );

    rrst_ram #(
        .DEPTH (rrst_pkg::DEPTH),
        .WIDTH (rrst_pkg::SUM_W)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_wr.we),
        .waddr (sum_wr.addr),
        .wdata (sum_wr.data),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    rrst_ram #(
        .DEPTH (rrst_pkg::DEPTH),
        .WIDTH (rrst_pkg::SUM_W)
    ) u_add_ram (
        .aclk  (aclk),
        .we    (add_wr.we),
        .waddr (add_wr.addr),
        .wdata (add_wr.data),
        .raddr (add_raddr),
        .rdata (add_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_sum_next   = m_sum_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res.valid && res_ready) begin
            m_valid_next = 1'b1;
            m_sum_next   = res.sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_sum_reg <= m_sum_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;

endmodule
